FILE: design/kce_pkg.sv
// Shared types and constants for the k-combination enumerator.
// Used by kce_pos_store, k_combination_enumerator and the testbench; depends on nothing.
package kce_pkg;

	// Alphabet size limit and the widths that follow from it.
	localparam int MAX_SYMBOLS = 32;
	localparam int IDX_W       = $clog2(MAX_SYMBOLS);
	localparam int LEN_W       = 6;
	localparam int COUNT_W     = 30;
	localparam int WORD_W      = 64;
	localparam int NUM_WORDS   = 4;
	localparam int CFG_IDX_W   = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [LEN_W-1:0]   N_LIMIT   = LEN_W'(MAX_SYMBOLS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBO_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_WORD0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_WORD1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_WORD2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_WORD3 = 3'd5;

	// Error codes reported with each result word.
	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_EXHAUSTED = 2'd1;
	localparam logic [1:0] ERR_LENGTH    = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_EMIT
	} state_t;

	// Write port of the position index store.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} pos_wr_t;

endpackage

FILE: design/kce_pos_store.sv
// Position index store of the k-combination enumerator: one entry per position.
// Depends on kce_pkg for widths and the write port struct.
module kce_pos_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  kce_pkg::pos_wr_t            wr,
	input  logic [kce_pkg::IDX_W-1:0]   rd_addr,
	output logic [kce_pkg::IDX_W-1:0]   rd_data,
	output logic [kce_pkg::IDX_W-1:0]   head
);

	logic [kce_pkg::IDX_W-1:0] pos_q [kce_pkg::MAX_SYMBOLS];

	// Entry i holds i after reset or restart; otherwise one entry is written per cycle while the write port is enabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kce_pkg::MAX_SYMBOLS; i++) begin
				pos_q[i] <= kce_pkg::IDX_W'(i);
			end
		end else if (restart) begin
			for (int i = 0; i < kce_pkg::MAX_SYMBOLS; i++) begin
				pos_q[i] <= kce_pkg::IDX_W'(i);
			end
		end else if (wr.en) begin
			pos_q[wr.addr] <= wr.data;
		end
	end

	// One selected read for the sequencer and the first entry for the exhaustion test.
	assign rd_data = pos_q[rd_addr];
	assign head    = pos_q[0];

endmodule

FILE: design/k_combination_enumerator.sv
// Top level of the k-combination enumerator: configuration, sequencer and output word.
// Depends on kce_pkg and kce_pos_store.
// A status query or an error answer appears in the output word the cycle after its input word.
// An advance steps from idle through a scan for the pivot and a refill of the suffix
// (the first advance goes straight to emission), then emits its k elements, one output word
// per cycle while the receiver accepts them, all through the single index store read port.
// Reset clears the sequencer and output valid, sets n=32, k=1, the alphabet to zeros
// and the enumeration to its start; a write to a listed configuration register restarts it at once.
module k_combination_enumerator (
	input  logic        clk,
	input  logic        arst_n,
	// Input words.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] advance, [7:1] zero
	// Output words.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [4:0] position, [9:5] symbol_index, [17:10] symbol_byte,
	                               // [18] has_more, [48:19] generated_count, [55:49] zero
	output logic [2:0]  m_tuser,   // [0] symbol_valid, [2:1] error_code
	output logic        m_tlast,
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int IDX_W   = kce_pkg::IDX_W;
	localparam int LEN_W   = kce_pkg::LEN_W;
	localparam int COUNT_W = kce_pkg::COUNT_W;

	// Configuration registers.
	logic [LEN_W-1:0]           symbol_count_q;
	logic [LEN_W-1:0]           combo_length_q;
	logic [kce_pkg::WORD_W-1:0] symbols_q [kce_pkg::NUM_WORDS];

	// Enumeration state and sequencer.
	kce_pkg::state_t    state_q, state_d;
	logic               first_q, first_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0]   p_q, p_d;
	logic [IDX_W-1:0]   i_q, i_d;
	logic [IDX_W-1:0]   prev_q, prev_d;
	logic [IDX_W-1:0]   e_q, e_d;

	// Output register.
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_pos_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [7:0]         out_byte_q;
	logic               out_sv_q;
	logic               out_last_q;
	logic               out_more_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [1:0]         out_err_q;

	logic               restart;
	logic               in_accept;
	logic               out_free;
	logic [LEN_W-1:0]   n_eff;
	logic               cfg_ok;
	logic               more;
	logic [LEN_W-1:0]   n_minus_k;
	logic [LEN_W-1:0]   scan_limit;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   rd_data;
	logic [IDX_W-1:0]   head;
	logic [IDX_W-1:0]   rd_inc;
	logic [kce_pkg::WORD_W-1:0] sym_word;
	logic [7:0]         sym_byte;
	kce_pkg::pos_wr_t   wr;
	logic               load_single;
	logic               load_elem;
	logic [1:0]         single_err;
	logic               elem_last;

	// A write to a listed register restarts the enumeration.
	always_comb begin
		unique case (cfg_index)
			kce_pkg::CFG_SYMBOL_COUNT, kce_pkg::CFG_COMBO_LENGTH,
			kce_pkg::CFG_SYMBOLS_WORD0, kce_pkg::CFG_SYMBOLS_WORD1,
			kce_pkg::CFG_SYMBOLS_WORD2, kce_pkg::CFG_SYMBOLS_WORD3: restart = cfg_we;
			default: restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= kce_pkg::N_LIMIT;
			combo_length_q <= LEN_W'(1);
			for (int w = 0; w < kce_pkg::NUM_WORDS; w++) begin
				symbols_q[w] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				kce_pkg::CFG_SYMBOL_COUNT:  symbol_count_q <= cfg_data[LEN_W-1:0];
				kce_pkg::CFG_COMBO_LENGTH:  combo_length_q <= cfg_data[LEN_W-1:0];
				kce_pkg::CFG_SYMBOLS_WORD0: symbols_q[0]   <= cfg_data;
				kce_pkg::CFG_SYMBOLS_WORD1: symbols_q[1]   <= cfg_data;
				kce_pkg::CFG_SYMBOLS_WORD2: symbols_q[2]   <= cfg_data;
				kce_pkg::CFG_SYMBOLS_WORD3: symbols_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Configuration checks and the has-more flag, taken from the current state.
	assign n_eff     = (symbol_count_q > kce_pkg::N_LIMIT) ? kce_pkg::N_LIMIT : symbol_count_q;
	assign cfg_ok    = (combo_length_q != '0) && (combo_length_q <= n_eff);
	assign n_minus_k = n_eff - combo_length_q;
	assign more      = cfg_ok && (first_q || ({1'b0, head} < n_minus_k));

	// The store is read at the scan pointer while scanning, at the emit pointer otherwise.
	assign rd_addr    = (state_q == kce_pkg::ST_SCAN) ? p_q : e_q;
	assign rd_inc     = rd_data + IDX_W'(1);
	assign scan_limit = n_minus_k + {1'b0, p_q};
	assign elem_last  = (({1'b0, e_q} + LEN_W'(1)) == combo_length_q);

	// Alphabet byte of the element being emitted.
	assign sym_word = symbols_q[rd_data[IDX_W-1:3]];
	assign sym_byte = sym_word[{rd_data[2:0], 3'b000} +: 8];

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == kce_pkg::ST_IDLE) && out_free;
	assign in_accept = s_tvalid && s_tready;

	kce_pos_store u_pos_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.head    (head)
	);

	// Sequencer: pivot scan, suffix refill and serial emission.
	always_comb begin
		state_d     = state_q;
		first_d     = first_q;
		count_d     = count_q;
		p_d         = p_q;
		i_d         = i_q;
		prev_d      = prev_q;
		e_d         = e_q;
		wr          = '0;
		load_single = 1'b0;
		load_elem   = 1'b0;
		single_err  = kce_pkg::ERR_OK;
		unique case (state_q)
			kce_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (!s_tdata[0]) begin
						load_single = 1'b1;
						single_err  = cfg_ok ? kce_pkg::ERR_OK : kce_pkg::ERR_LENGTH;
					end else if (!cfg_ok) begin
						load_single = 1'b1;
						single_err  = kce_pkg::ERR_LENGTH;
					end else if (!more) begin
						load_single = 1'b1;
						single_err  = kce_pkg::ERR_EXHAUSTED;
					end else begin
						if (count_q != kce_pkg::COUNT_MAX) begin
							count_d = count_q + COUNT_W'(1);
						end
						e_d = '0;
						if (first_q) begin
							first_d = 1'b0;
							state_d = kce_pkg::ST_EMIT;
						end else begin
							p_d     = IDX_W'(combo_length_q - LEN_W'(1));
							state_d = kce_pkg::ST_SCAN;
						end
					end
				end
			end
			kce_pkg::ST_SCAN: begin
				if ((p_q != '0) && ({1'b0, rd_data} >= scan_limit)) begin
					p_d = p_q - IDX_W'(1);
				end else begin
					// Raise the pivot and start refilling after it.
					wr.en   = 1'b1;
					wr.addr = p_q;
					wr.data = rd_inc;
					prev_d  = rd_inc;
					i_d     = p_q + IDX_W'(1);
					if (({1'b0, p_q} + LEN_W'(1)) < combo_length_q) begin
						state_d = kce_pkg::ST_FILL;
					end else begin
						state_d = kce_pkg::ST_EMIT;
					end
				end
			end
			kce_pkg::ST_FILL: begin
				wr.en   = 1'b1;
				wr.addr = i_q;
				wr.data = prev_q + IDX_W'(1);
				prev_d  = prev_q + IDX_W'(1);
				if (({1'b0, i_q} + LEN_W'(1)) < combo_length_q) begin
					i_d = i_q + IDX_W'(1);
				end else begin
					state_d = kce_pkg::ST_EMIT;
				end
			end
			kce_pkg::ST_EMIT: begin
				if (out_free) begin
					load_elem = 1'b1;
					if (elem_last) begin
						state_d = kce_pkg::ST_IDLE;
					end else begin
						e_d = e_q + IDX_W'(1);
					end
				end
			end
			default: state_d = kce_pkg::ST_IDLE;
		endcase
	end

	// Sequencer and enumeration registers; a restart takes priority for the first flag and the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kce_pkg::ST_IDLE;
			first_q <= 1'b1;
			count_q <= '0;
			p_q     <= '0;
			i_q     <= '0;
			prev_q  <= '0;
			e_q     <= '0;
		end else begin
			state_q <= state_d;
			p_q     <= p_d;
			i_q     <= i_d;
			prev_q  <= prev_d;
			e_q     <= e_d;
			if (restart) begin
				first_q <= 1'b1;
				count_q <= '0;
			end else begin
				first_q <= first_d;
				count_q <= count_d;
			end
		end
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_single || load_elem) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload; has-more and the count reflect the state after the update.
	always_ff @(posedge clk) begin
		if (load_single) begin
			out_pos_q   <= '0;
			out_idx_q   <= '0;
			out_byte_q  <= '0;
			out_sv_q    <= 1'b0;
			out_last_q  <= 1'b1;
			out_more_q  <= more;
			out_count_q <= count_q;
			out_err_q   <= single_err;
		end else if (load_elem) begin
			out_pos_q   <= e_q;
			out_idx_q   <= rd_data;
			out_byte_q  <= sym_byte;
			out_sv_q    <= 1'b1;
			out_last_q  <= elem_last;
			out_more_q  <= more;
			out_count_q <= count_q;
			out_err_q   <= kce_pkg::ERR_OK;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_count_q, out_more_q, out_byte_q, out_idx_q, out_pos_q};
	assign m_tuser  = {out_err_q, out_sv_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: tb/kce_checker.sv
// Checker for the k-combination enumerator: watches the input, output and configuration ports,
// predicts every output word from its own copy of the enumeration state and compares.
// Depends on kce_pkg; instantiated beside the block by k_combination_enumerator_test.
module kce_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] advance, [7:1] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,   // [4:0] position, [9:5] symbol_index, [17:10] symbol_byte,
	                               // [18] has_more, [48:19] generated_count, [55:49] zero
	input  logic [2:0]  m_tuser,   // [0] symbol_valid, [2:1] error_code
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          pending,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;

	// One output word as the block should present it.
	typedef struct packed {
		logic [kce_pkg::IDX_W-1:0]   position;
		logic [kce_pkg::IDX_W-1:0]   symbol_index;
		logic [7:0]                  symbol_byte;
		logic                        symbol_valid;
		logic                        last;
		logic                        has_more;
		logic [kce_pkg::COUNT_W-1:0] count;
		logic [1:0]                  error_code;
	} combo_word_t;

	// Own copy of the configuration and the enumeration state.
	logic [kce_pkg::LEN_W-1:0]   alpha_size;
	logic [kce_pkg::LEN_W-1:0]   combo_len;
	logic [kce_pkg::WORD_W-1:0]  alphabet [kce_pkg::NUM_WORDS];
	logic [kce_pkg::IDX_W-1:0]   chosen [kce_pkg::MAX_SYMBOLS];
	logic                        start_due;
	logic [kce_pkg::COUNT_W-1:0] combos_made;
	combo_word_t                 words_due [$];

	// An alphabet size above the limit behaves as the limit.
	function automatic int unsigned usable_size();
		return (alpha_size > kce_pkg::MAX_SYMBOLS) ? kce_pkg::MAX_SYMBOLS : int'(alpha_size);
	endfunction

	function automatic bit length_ok();
		return combo_len != 0 && combo_len <= usable_size();
	endfunction

	function automatic bit more_left();
		if (!length_ok())
			return 1'b0;
		return start_due || (chosen[0] < usable_size() - combo_len);
	endfunction

	function automatic logic [7:0] symbol_of(input logic [kce_pkg::IDX_W-1:0] idx);
		return alphabet[idx[4:3]][{idx[2:0], 3'b000} +: 8];
	endfunction

	// Back to the starting combination 0, 1, 2, ...
	task automatic restart_walk();
		for (int i = 0; i < kce_pkg::MAX_SYMBOLS; i++)
			chosen[i] = kce_pkg::IDX_W'(i);
		start_due   = 1'b1;
		combos_made = '0;
	endtask

	// Raise the rightmost position that still can be raised and refill the ones after it.
	task automatic step_walk();
		int n;
		int k;
		int p;
		n = usable_size();
		k = combo_len;
		p = k - 1;
		while (p > 0 && int'(chosen[p]) >= n - k + p)
			p--;
		chosen[p] = chosen[p] + 1'b1;
		for (int i = p + 1; i < k; i++)
			chosen[i] = chosen[i-1] + 1'b1;
	endtask

	task automatic queue_word(input logic [kce_pkg::IDX_W-1:0] pos,
	                          input logic [kce_pkg::IDX_W-1:0] idx,
	                          input logic valid, input logic last, input logic [1:0] err);
		combo_word_t w;
		w.position     = pos;
		w.symbol_index = idx;
		w.symbol_byte  = valid ? symbol_of(idx) : 8'd0;
		w.symbol_valid = valid;
		w.last         = last;
		w.has_more     = more_left();
		w.count        = combos_made;
		w.error_code   = err;
		words_due.push_back(w);
	endtask

	// Expected words for one accepted request.
	task automatic predict_request(input logic advance);
		int k;
		if (!advance) begin
			queue_word('0, '0, 1'b0, 1'b1,
			           length_ok() ? kce_pkg::ERR_OK : kce_pkg::ERR_LENGTH);
		end else if (!length_ok()) begin
			queue_word('0, '0, 1'b0, 1'b1, kce_pkg::ERR_LENGTH);
		end else if (!more_left()) begin
			queue_word('0, '0, 1'b0, 1'b1, kce_pkg::ERR_EXHAUSTED);
		end else begin
			if (start_due)
				start_due = 1'b0;
			else
				step_walk();
			if (combos_made != kce_pkg::COUNT_MAX)
				combos_made++;
			k = combo_len;
			for (int i = 0; i < k; i++)
				queue_word(kce_pkg::IDX_W'(i), chosen[i], 1'b1, i == k - 1, kce_pkg::ERR_OK);
		end
	endtask

	// A write to a known register restarts the enumeration; other indexes are ignored.
	task automatic apply_write(input logic [2:0] idx, input logic [63:0] data);
		bit known;
		known = 1'b1;
		case (idx)
			kce_pkg::CFG_SYMBOL_COUNT:  alpha_size = data[kce_pkg::LEN_W-1:0];
			kce_pkg::CFG_COMBO_LENGTH:  combo_len  = data[kce_pkg::LEN_W-1:0];
			kce_pkg::CFG_SYMBOLS_WORD0: alphabet[0] = data;
			kce_pkg::CFG_SYMBOLS_WORD1: alphabet[1] = data;
			kce_pkg::CFG_SYMBOLS_WORD2: alphabet[2] = data;
			kce_pkg::CFG_SYMBOLS_WORD3: alphabet[3] = data;
			default:                    known = 1'b0;
		endcase
		if (known)
			restart_walk();
	endtask

	task automatic report(input string what, input longint unsigned got_v,
	                      input longint unsigned want_v);
		if (failures < 60)
			$display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got_v, want_v);
		failures++;
	endtask

	task automatic check_field(input string what, input longint unsigned got_v,
	                           input longint unsigned want_v);
		if (got_v != want_v)
			report(what, got_v, want_v);
	endtask

	// Compare each output word, then take in new requests and register writes.
	always @(posedge clk or negedge arst_n) begin : watch
		int          added;
		int          taken;
		int          size_was;
		combo_word_t want;
		combo_word_t got;
		if (!arst_n) begin
			alpha_size = kce_pkg::LEN_W'(kce_pkg::MAX_SYMBOLS);
			combo_len  = kce_pkg::LEN_W'(1);
			for (int w = 0; w < kce_pkg::NUM_WORDS; w++)
				alphabet[w] = '0;
			restart_walk();
			words_due.delete();
			pending  <= 0;
			failures = 0;
		end else begin
			added = 0;
			taken = 0;
			if (m_tvalid && m_tready) begin
				got.position     = m_tdata[4:0];
				got.symbol_index = m_tdata[9:5];
				got.symbol_byte  = m_tdata[17:10];
				got.has_more     = m_tdata[18];
				got.count        = m_tdata[48:19];
				got.symbol_valid = m_tuser[0];
				got.error_code   = m_tuser[2:1];
				got.last         = m_tlast;
				if (words_due.size() == 0) begin
					report("word with nothing outstanding, position", got.position, 0);
				end else begin
					want  = words_due.pop_front();
					taken = 1;
					check_field("position", got.position, want.position);
					check_field("symbol_index", got.symbol_index, want.symbol_index);
					check_field("symbol_byte", got.symbol_byte, want.symbol_byte);
					check_field("symbol_valid", got.symbol_valid, want.symbol_valid);
					check_field("last", got.last, want.last);
					check_field("has_more", got.has_more, want.has_more);
					check_field("generated_count", got.count, want.count);
					check_field("error_code", got.error_code, want.error_code);
				end
			end
			if (s_tvalid && s_tready) begin
				size_was = words_due.size();
				predict_request(s_tdata[0]);
				added = words_due.size() - size_was;
			end
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			pending <= pending + added - taken;
		end
	end

endmodule

FILE: tb/k_combination_enumerator_test.sv
// Testbench top for the k-combination enumerator: clock, reset, request and register stimulus.
// Depends on kce_pkg, k_combination_enumerator and kce_checker, which predicts and compares.
module k_combination_enumerator_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes the block does not implement; writes to them must be ignored.
	localparam logic [kce_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [kce_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] advance, [7:1] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [4:0] position, [9:5] symbol_index, [17:10] symbol_byte,
	                        // [18] has_more, [48:19] generated_count, [55:49] zero
	logic [2:0]  m_tuser;   // [0] symbol_valid, [2:1] error_code
	logic        m_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	int pending;
	int failures;
	bit calm = 1'b0;
	bit hold_long = 1'b0;

	k_combination_enumerator i_dut (.*);

	kce_checker i_checker (.*);

	// Clock, period 8 ns.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random bursts of back-pressure, one long hold-off on request, none when calm.
	initial begin : receiver
		m_tready <= 1'b0;
		forever begin
			if (hold_long) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_long = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Offer one request word, now and then after an idle burst, and wait for it to be taken.
	task automatic send_request(input bit advance);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, advance};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stop offering and wait until every expected word has come out.
	task automatic wait_all_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [kce_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic load_setup(input logic [5:0] n, input logic [5:0] k,
	                          input logic [63:0] w0, input logic [63:0] w1,
	                          input logic [63:0] w2, input logic [63:0] w3);
		set_reg(kce_pkg::CFG_SYMBOLS_WORD0, w0);
		set_reg(kce_pkg::CFG_SYMBOLS_WORD1, w1);
		set_reg(kce_pkg::CFG_SYMBOLS_WORD2, w2);
		set_reg(kce_pkg::CFG_SYMBOLS_WORD3, w3);
		set_reg(kce_pkg::CFG_SYMBOL_COUNT, {58'd0, n});
		set_reg(kce_pkg::CFG_COMBO_LENGTH, {58'd0, k});
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int          random_sent;
		int          phase_len;
		int          pick;
		int          usable;
		logic [5:0]  cur_n;
		logic [5:0]  cur_k;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset: query, then the first two single-symbol combinations.
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b1);
		wait_all_done();

		// Two of four: all six combinations, then exhausted, then a status query.
		load_setup(6'd4, 6'd2, 64'h0000_0000_d4c3_b2a1, '0, '0, '0);
		repeat (7) send_request(1'b1);
		send_request(1'b0);
		wait_all_done();

		// Writes to unknown indexes must not restart a finished walk.
		load_setup(6'd3, 6'd3, 64'h1122_3344_5566_7788, '1, '0, '1);
		send_request(1'b1);
		wait_all_done();
		set_reg(CFG_SPARE_LO, {$urandom, $urandom});
		set_reg(CFG_SPARE_HI, '1);
		cfg_we <= 1'b0;
		send_request(1'b1);
		send_request(1'b0);
		wait_all_done();

		// Zero length, then length above the alphabet size.
		set_reg(kce_pkg::CFG_COMBO_LENGTH, 64'd0);
		cfg_we <= 1'b0;
		send_request(1'b1);
		send_request(1'b0);
		wait_all_done();
		set_reg(kce_pkg::CFG_SYMBOL_COUNT, 64'd5);
		set_reg(kce_pkg::CFG_COMBO_LENGTH, 64'd6);
		cfg_we <= 1'b0;
		send_request(1'b1);
		wait_all_done();

		// Oversized alphabet treated as the limit, full-length combination.
		load_setup(6'd63, 6'd32, '1, 64'h0123_4567_89ab_cdef, {$urandom, $urandom},
		           64'h8000_0000_0000_0001);
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b0);
		wait_all_done();

		// Single-symbol alphabet, then an empty one.
		load_setup(6'd1, 6'd1, 64'h0000_0000_0000_005a, '0, '0, '0);
		send_request(1'b1);
		send_request(1'b1);
		wait_all_done();
		set_reg(kce_pkg::CFG_SYMBOL_COUNT, 64'd0);
		cfg_we <= 1'b0;
		send_request(1'b1);
		wait_all_done();

		// Long receiver hold-off while requests keep coming, then a full drain.
		load_setup(6'd20, 6'd12, {$urandom, $urandom}, {$urandom, $urandom},
		           {$urandom, $urandom}, {$urandom, $urandom});
		cur_n = 6'd20;
		cur_k = 6'd12;
		hold_long = 1'b1;
		repeat (12) send_request(1'b1);
		wait_all_done();

		// Random phases: mostly small alphabets so the walks run to exhaustion.
		random_sent = 0;
		while (random_sent < 225) begin
			calm = random_sent > 180;
			wait_all_done();
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					cur_n = 6'd0;
				else if (pick < 3)
					cur_n = 6'($urandom_range(33, 63));
				else if (pick < 6)
					cur_n = 6'($urandom_range(9, 32));
				else
					cur_n = 6'($urandom_range(1, 8));
				set_reg(kce_pkg::CFG_SYMBOL_COUNT, {58'd0, cur_n});
			end
			if ($urandom_range(0, 3) != 0) begin
				usable = (cur_n > kce_pkg::MAX_SYMBOLS) ? kce_pkg::MAX_SYMBOLS : cur_n;
				pick = $urandom_range(0, 19);
				if (pick < 2)
					cur_k = 6'd0;
				else if (pick < 4)
					cur_k = 6'($urandom_range(usable + 1, 63));
				else
					cur_k = 6'($urandom_range(1, (usable == 0) ? 1 : usable));
				set_reg(kce_pkg::CFG_COMBO_LENGTH, {58'd0, cur_k});
			end
			if ($urandom_range(0, 2) == 0)
				set_reg(kce_pkg::CFG_SYMBOLS_WORD0, {$urandom, $urandom});
			if ($urandom_range(0, 2) == 0)
				set_reg(kce_pkg::CFG_SYMBOLS_WORD1, {$urandom, $urandom});
			if ($urandom_range(0, 2) == 0)
				set_reg(kce_pkg::CFG_SYMBOLS_WORD2, {$urandom, $urandom});
			if ($urandom_range(0, 2) == 0)
				set_reg(kce_pkg::CFG_SYMBOLS_WORD3, {$urandom, $urandom});
			if ($urandom_range(0, 7) == 0)
				set_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});
			cfg_we <= 1'b0;
			phase_len = $urandom_range(2, 30);
			repeat (phase_len) begin
				send_request($urandom_range(0, 99) < 85);
				random_sent++;
			end
		end

		wait_all_done();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard limit on the run time.
	initial begin : watchdog
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
